>>> rtl/header_length_checksum_deframer_macros.svh
// Assertion macros shared by the deframer RTL
`ifndef HEADER_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH
`define HEADER_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset
`define HLCD_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define HLCD_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define HLCD_ASSERT_IMP(lbl, pre, post, msg)
`define HLCD_ASSERT_NXT(lbl, pre, post, msg)

`endif

`endif

>>> rtl/hlcd_pkg.sv
// Shared types, constants and helpers for the deframer
`timescale 1ns / 1ps

package hlcd_pkg;

    localparam int FIXED_BYTES = 7;
    localparam logic [15:0] SYNC_RESET = 16'hAABB;
    localparam logic [16:0] MAX_RESET = 17'd1023;

    // Result queue, depth must be a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_ENDIAN = 2'd0,
        REG_SYNC   = 2'd1,
        REG_MAX    = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CKSUM    = 2'd1,
        ST_OVERSIZE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_LEN0 = 4'b0010,
        PH_LEN1 = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    typedef struct packed {
        logic        big_endian;
        logic [15:0] sync_word;
        logic [16:0] max_frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [1:0] status;
    } beat_t;

    // Up to two beats per accepted byte; wr1 only together with wr0
    typedef struct packed {
        logic  wr0;
        logic  wr1;
        beat_t b0;
        beat_t b1;
    } push_t;

    function automatic logic [15:0] join_pair(input logic big_endian,
                                              input logic [7:0] earlier,
                                              input logic [7:0] later);
        logic [15:0] word;
        if (big_endian)
        begin
            word = {earlier, later};
        end
        else
        begin
            word = {later, earlier};
        end
        return word;
    endfunction

endpackage

>>> rtl/header_length_checksum_deframer.sv
// Deframer top level: config registers, front end and result queue
// An accepted byte's beat is written to the result queue at the edge that accepts it.
// Throughput: one byte per cycle in and one beat per cycle out, each unless stalled;
// a sync match yields two beats from one byte, and the four-beat result queue absorbs
// the extra beat. in_stall rises while the queue holds more than two beats.
// Reset: asynchronous, active low; clears the parser and the queue, config to defaults.
`timescale 1ns / 1ps

module header_length_checksum_deframer
    import hlcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               first,
    output logic               last,
    output logic [1:0]         status
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic     accept;
    logic     full2;
    push_t    push;
    beat_t    head;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.big_endian      <= 1'b0;
            cfg_reg.sync_word       <= SYNC_RESET;
            cfg_reg.max_frame_bytes <= MAX_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ENDIAN: cfg_reg.big_endian      <= pwdata[0];
                REG_SYNC:   cfg_reg.sync_word       <= pwdata[15:0];
                REG_MAX:    cfg_reg.max_frame_bytes <= pwdata[16:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ENDIAN: prdata = {31'd0, cfg_reg.big_endian};
            REG_SYNC:   prdata = {16'd0, cfg_reg.sync_word};
            REG_MAX:    prdata = {15'd0, cfg_reg.max_frame_bytes};
            default:    prdata = '0;
        endcase
    end

    assign in_stall = full2;
    assign accept   = in_valid && !in_stall;

    hlcd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .cfg     (cfg_reg),
        .push    (push)
    );

    hlcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_valid && !out_stall),
        .full2      (full2),
        .head_valid (out_valid),
        .head       (head)
    );

    assign out_byte = head.data;
    assign first    = head.first;
    assign last     = head.last;
    assign status   = head.status;

endmodule

>>> rtl/hlcd_front.sv
// Front end: sync hunt, length decode, checksum and beat classification
`timescale 1ns / 1ps
`include "header_length_checksum_deframer_macros.svh"

module hlcd_front
    import hlcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  cfg_t       cfg,
    output push_t      push
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  prev_reg, prev_next;
    logic        have_prev_reg, have_prev_next;
    logic [7:0]  len_first_reg, len_first_next;
    logic [16:0] remain_reg, remain_next;
    logic [7:0]  sum_reg, sum_next;

    logic [15:0] pair_word;
    logic [16:0] total;

    assign pair_word = (phase_reg == PH_HUNT)
                     ? join_pair(cfg.big_endian, prev_reg, in_byte)
                     : join_pair(cfg.big_endian, len_first_reg, in_byte);
    assign total = {1'b0, pair_word} + 17'(FIXED_BYTES);

    always_comb
    begin
        phase_next     = phase_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        len_first_next = len_first_reg;
        remain_next    = remain_reg;
        sum_next       = sum_reg;
        push           = '0;
        push.b0.data   = in_byte;
        push.b1.data   = in_byte;

        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (have_prev_reg && (pair_word == cfg.sync_word))
                    begin
                        push.wr0          = 1'b1;
                        push.wr1          = 1'b1;
                        push.b0.data      = prev_reg;
                        push.b0.first     = 1'b1;
                        sum_next          = prev_reg + in_byte;
                        have_prev_next    = 1'b0;
                        phase_next        = PH_LEN0;
                    end
                    else
                    begin
                        prev_next      = in_byte;
                        have_prev_next = 1'b1;
                    end
                end
                PH_LEN0:
                begin
                    push.wr0       = 1'b1;
                    len_first_next = in_byte;
                    sum_next       = sum_reg + in_byte;
                    phase_next     = PH_LEN1;
                end
                PH_LEN1:
                begin
                    push.wr0 = 1'b1;
                    if (total > cfg.max_frame_bytes)
                    begin
                        // drop the frame, flag on this byte
                        push.b0.last   = 1'b1;
                        push.b0.status = ST_OVERSIZE;
                        phase_next     = PH_HUNT;
                        have_prev_next = 1'b0;
                        prev_next      = '0;
                        sum_next       = '0;
                        remain_next    = '0;
                    end
                    else
                    begin
                        sum_next    = sum_reg + in_byte;
                        remain_next = total - 17'd4;
                        phase_next  = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    push.wr0 = 1'b1;
                    if (remain_reg <= 17'd1)
                    begin
                        push.b0.last   = 1'b1;
                        push.b0.status = (in_byte == sum_reg) ? ST_OK : ST_CKSUM;
                        phase_next     = PH_HUNT;
                        have_prev_next = 1'b0;
                        prev_next      = '0;
                        sum_next       = '0;
                        remain_next    = '0;
                    end
                    else
                    begin
                        sum_next    = sum_reg + in_byte;
                        remain_next = remain_reg - 17'd1;
                    end
                end
                default:
                begin
                    phase_next     = PH_HUNT;
                    have_prev_next = 1'b0;
                    prev_next      = '0;
                    sum_next       = '0;
                    remain_next    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            len_first_reg <= '0;
            remain_reg    <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            len_first_reg <= len_first_next;
            remain_reg    <= remain_next;
            sum_reg       <= sum_next;
        end
    end

    `HLCD_ASSERT_IMP(a_pair_only_on_sync, push.wr1, (phase_reg == PH_HUNT) && push.b0.first, "two-beat push outside sync match")
    `HLCD_ASSERT_IMP(a_one_beat_in_frame, accept && (phase_reg != PH_HUNT), push.wr0 && !push.wr1, "frame byte did not push exactly one beat")
    `HLCD_ASSERT_NXT(a_last_rehunts, accept && push.wr0 && push.b0.last, (phase_reg == PH_HUNT) && !have_prev_reg, "hunt not restarted after frame end")

endmodule

>>> rtl/hlcd_queue.sv
// Back end: small result queue, two writes and one read per cycle
`timescale 1ns / 1ps
`include "header_length_checksum_deframer_macros.svh"

module hlcd_queue
    import hlcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  full2,
    output logic  head_valid,
    output beat_t head
);

    beat_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic [QPTR_W-1:0]  wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign head_valid   = (cnt_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    // hold off input unless two free slots remain
    assign full2        = (cnt_reg > QCNT_W'(QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.wr0) + QPTR_W'(push.wr1);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(push.wr0) + QCNT_W'(push.wr1) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.wr0)
        begin
            mem_reg[wr_ptr_reg] <= push.b0;
        end
        if (push.wr1)
        begin
            mem_reg[wr_ptr_plus1] <= push.b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `HLCD_ASSERT_IMP(a_no_overflow, push.wr0, !full2, "beat pushed while queue lacks room")
    `HLCD_ASSERT_IMP(a_no_underflow, pop, head_valid, "pop from empty queue")

endmodule
